// File: rtl/fm0_node_packet_transmitter_assert.svh
// Assertion macros for the FM0 node packet transmitter.
// Used by the top level; relies on the signals clk and rst in the including scope.
`ifndef FM0_NODE_PACKET_TRANSMITTER_ASSERT_SVH
`define FM0_NODE_PACKET_TRANSMITTER_ASSERT_SVH

// When the antecedent holds at a clock edge, the consequent holds at the same edge.
`define FM0_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fm0 implication check failed");

// The expression never holds at a clock edge.
`define FM0_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("fm0 forbidden condition seen");

`endif

// File: rtl/fm0_pkg.sv
// Shared types and constants for the FM0 node packet transmitter.
// No dependencies; imported by every module of the block.
package fm0_pkg;

  // Frame layout: six start bits, then address and data nibbles.
  localparam int unsigned FRAME_BITS = 14;
  localparam logic [5:0]  START_PATTERN = 6'b111010;

  // Configuration register indexes.
  localparam logic [1:0] CFG_HALF_BIT = 2'd0;
  localparam logic [1:0] CFG_GAP      = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [7:0]  HALF_BIT_RESET = 8'd5;
  localparam logic [15:0] GAP_RESET      = 16'd400;

  // Input kind carried on tuser.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_SEND = 2'd1,
    MODE_GAP  = 2'd2
  } mode_t;

  // One result word.
  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic accepted;
    logic packet_done;
  } result_t;

  // Internal status of the encoder, used for checking.
  typedef struct packed {
    mode_t      mode;
    logic [3:0] bit_count;
    logic       tick_zero;
  } status_t;

endpackage

// File: rtl/fm0_cfg.sv
// Configuration registers of the FM0 node packet transmitter.
// Depends on fm0_pkg for register indexes and reset values.
module fm0_cfg import fm0_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic [7:0]  half_bit_ticks,
  output logic [15:0] gap_ticks
);

  // The register file can take a word every cycle.
  assign cfg_ready = 1'b1;

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_bit_ticks <= HALF_BIT_RESET;
      gap_ticks      <= GAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HALF_BIT: half_bit_ticks <= cfg_data[7:0];
        CFG_GAP:      gap_ticks      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/fm0_core.sv
// FM0 encoder state and its single-pass next-state logic.
// Depends on fm0_pkg; one input word is processed per enabled cycle.
module fm0_core import fm0_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic        op,
  input  logic [3:0]  node_address,
  input  logic [3:0]  data_nibble,
  input  logic [7:0]  half_bit_ticks,
  input  logic [15:0] gap_ticks,
  output result_t     result,
  output status_t     status
);

  mode_t       mode, mode_next;
  logic [13:0] frame_shift, frame_shift_next;
  logic [3:0]  bit_count, bit_count_next;
  logic        half_phase, half_phase_next;
  logic [15:0] tick_count, tick_count_next;
  logic        line_reg, line_reg_next;

  logic [7:0]  half_len;
  logic [13:0] shifted;
  logic [3:0]  bit_count_inc;
  logic        accepted;
  logic        done;

  // Ticks minus one of the first segment of a bit: a one spans two half periods.
  function automatic logic [15:0] seg_ticks(input logic bit_val, input logic [7:0] hl);
    logic [8:0] full;
    full = {hl, 1'b0} - 9'd1;
    return bit_val ? {7'd0, full} : {8'd0, hl - 8'd1};
  endfunction

  assign half_len      = (half_bit_ticks == 8'd0) ? 8'd1 : half_bit_ticks;
  assign shifted       = {frame_shift[12:0], 1'b0};
  assign bit_count_inc = bit_count + 4'd1;

  // Next state for one input word.
  always_comb begin
    mode_next        = mode;
    frame_shift_next = frame_shift;
    bit_count_next   = bit_count;
    half_phase_next  = half_phase;
    tick_count_next  = tick_count;
    line_reg_next    = line_reg;
    accepted         = 1'b0;
    done             = 1'b0;

    if (op == OP_LOAD) begin
      // A load starts a frame only when the line is idle.
      if (mode == MODE_IDLE) begin
        line_reg_next    = ~line_reg;
        frame_shift_next = {START_PATTERN, node_address, data_nibble};
        bit_count_next   = 4'd0;
        mode_next        = MODE_SEND;
        half_phase_next  = 1'b0;
        tick_count_next  = seg_ticks(1'b1, half_len);
        accepted         = 1'b1;
      end
    end else begin
      unique case (mode)
        MODE_SEND: begin
          if (tick_count != 16'd0) begin
            tick_count_next = tick_count - 16'd1;
          end else begin
            line_reg_next = ~line_reg;
            if (!frame_shift[13] && !half_phase) begin
              // Mid-cell toggle of a zero bit.
              half_phase_next = 1'b1;
              tick_count_next = {8'd0, half_len - 8'd1};
            end else begin
              half_phase_next  = 1'b0;
              frame_shift_next = shifted;
              bit_count_next   = bit_count_inc;
              if (bit_count_inc == 4'(FRAME_BITS)) begin
                done           = 1'b1;
                bit_count_next = 4'd0;
                if (gap_ticks == 16'd0) begin
                  mode_next       = MODE_IDLE;
                  tick_count_next = 16'd0;
                end else begin
                  mode_next       = MODE_GAP;
                  tick_count_next = gap_ticks;
                end
              end else begin
                tick_count_next = seg_ticks(shifted[13], half_len);
              end
            end
          end
        end
        MODE_GAP: begin
          if (tick_count != 16'd0) begin
            tick_count_next = tick_count - 16'd1;
          end
          if (tick_count_next == 16'd0) begin
            mode_next = MODE_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      frame_shift <= '0;
      bit_count   <= '0;
      half_phase  <= 1'b0;
      tick_count  <= '0;
      line_reg    <= 1'b0;
    end else if (step) begin
      mode        <= mode_next;
      frame_shift <= frame_shift_next;
      bit_count   <= bit_count_next;
      half_phase  <= half_phase_next;
      tick_count  <= tick_count_next;
      line_reg    <= line_reg_next;
    end
  end

  // Result of this word, taken into the output register by the top level.
  assign result.line_level  = line_reg_next;
  assign result.busy_res    = (mode_next == MODE_SEND) || (mode_next == MODE_GAP);
  assign result.accepted    = accepted;
  assign result.packet_done = done;

  assign status.mode      = mode;
  assign status.bit_count = bit_count;
  assign status.tick_zero = (tick_count == 16'd0);

endmodule

// File: rtl/fm0_node_packet_transmitter.sv
// FM0 node packet transmitter: one result word per input word, registered in the cycle after acceptance.
// Throughput is one word per clock; a new word can enter in the same cycle that the
// previous result is taken, so the input stalls only while a result is held.
// rst (synchronous) clears the encoder to idle with the line low, empties the output
// register, and sets half_bit_ticks to 5 and gap_ticks to 400.
`include "fm0_node_packet_transmitter_assert.svh"

module fm0_node_packet_transmitter import fm0_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [3:0] node_address, [7:4] data_nibble
  input  logic        s_tuser,   // [0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] line_level, [1] busy_res, [2] accepted, [7:3] zero
  output logic        m_tlast,   // packet_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [7:0]  half_bit_ticks;
  logic [15:0] gap_ticks;
  logic        in_fire;
  result_t     result;
  result_t     out_word;
  status_t     status;

  fm0_cfg u_cfg (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .half_bit_ticks (half_bit_ticks),
    .gap_ticks      (gap_ticks)
  );

  // Accept a word whenever the output register is free or being emptied.
  assign s_tready = !m_tvalid || m_tready;
  assign in_fire  = s_tvalid && s_tready;

  fm0_core u_core (
    .clk            (clk),
    .rst            (rst),
    .step           (in_fire),
    .op             (s_tuser),
    .node_address   (s_tdata[3:0]),
    .data_nibble    (s_tdata[7:4]),
    .half_bit_ticks (half_bit_ticks),
    .gap_ticks      (gap_ticks),
    .result         (result),
    .status         (status)
  );

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_word <= result;
    end
  end

  assign m_tdata = {5'd0, out_word.accepted, out_word.busy_res, out_word.line_level};
  assign m_tlast = out_word.packet_done;

  // A taken load always leaves the block busy.
  `FM0_ASSERT_IMPLIES(a_accept_busy, m_tvalid && out_word.accepted, out_word.busy_res)
  // A word never both starts and ends a frame.
  `FM0_ASSERT_NEVER(a_accept_done, m_tvalid && out_word.accepted && out_word.packet_done)
  // The idle encoder holds no pending ticks.
  `FM0_ASSERT_IMPLIES(a_idle_clear, status.mode == MODE_IDLE, status.tick_zero)
  // The bit counter stays within one frame.
  `FM0_ASSERT_NEVER(a_bit_range, status.bit_count >= 4'(FRAME_BITS))

endmodule

// File: verif/tb_fm0_node_packet_transmitter.sv
`timescale 1ns / 100ps
// Testbench for the FM0 node packet transmitter: directed rows, then random traffic
// over several register settings; checks use typed results or a built-in predictor.
// Depends on fm0_pkg and the fm0_node_packet_transmitter RTL only.

module tb_fm0_node_packet_transmitter;
  import fm0_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam logic [1:0]  CFG_UNUSED  = 2'd3;
  localparam int unsigned SQUEEZE_CYCLES = 200;

  typedef enum int {RUN_FOR_COUNT, RUN_TO_IDLE, RUN_ONE_BIT} run_goal_t;
  typedef enum int {READY_ALWAYS, READY_RANDOM, READY_PERIODIC} ready_style_t;

  // One directed row: the input word and, where it is obvious, the result word.
  typedef struct packed {
    logic       op;
    logic [3:0] addr;
    logic [3:0] nib;
    logic       typed;
    result_t    result;
  } probe_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = OP_TICK;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_HALF_BIT;
  logic [15:0] cfg_data = '0;

  // Predictor copy of the registers and the encoder state.
  logic [7:0]  half_cfg    = HALF_BIT_RESET;
  logic [15:0] gap_cfg     = GAP_RESET;
  logic [13:0] frame_q     = '0;
  logic [3:0]  bits_sent   = '0;
  logic        second_half = 1'b0;
  logic [15:0] ticks_left  = '0;
  logic        line_q      = 1'b0;
  mode_t       mode_q      = MODE_IDLE;

  result_t     line_words_q[$];
  int unsigned mismatches  = 0;
  int unsigned burst_left  = 0;
  int unsigned cycle_count = 0;
  logic        squeeze_req = 1'b0;

  fm0_node_packet_transmitter i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Tick count to load for a segment: a full cell for a 1, half a cell otherwise.
  function automatic logic [15:0] segment_reload(input logic full_cell);
    logic [15:0] h;
    h = (half_cfg == 8'd0) ? 16'd1 : {8'd0, half_cfg};
    return (full_cell ? (h << 1) : h) - 16'd1;
  endfunction

  // Advance the predicted encoder by one word and produce the result it causes.
  task automatic advance_encoder(input logic op, input logic [3:0] addr,
                                 input logic [3:0] nib, output result_t res);
    logic acc;
    logic done;
    acc = 1'b0;
    done = 1'b0;
    if (op == OP_LOAD) begin
      if (mode_q != MODE_SEND && mode_q != MODE_GAP) begin
        line_q = ~line_q;
        frame_q = {START_PATTERN, addr, nib};
        bits_sent = '0;
        mode_q = MODE_SEND;
        second_half = 1'b0;
        ticks_left = segment_reload(frame_q[13]);
        acc = 1'b1;
      end
    end else if (mode_q == MODE_SEND) begin
      if (ticks_left != 16'd0) begin
        ticks_left = ticks_left - 16'd1;
      end else begin
        line_q = ~line_q;
        if (!frame_q[13] && !second_half) begin
          // A zero also toggles in mid-cell.
          second_half = 1'b1;
          ticks_left = segment_reload(1'b0);
        end else begin
          second_half = 1'b0;
          frame_q = frame_q << 1;
          bits_sent = bits_sent + 4'd1;
          if (bits_sent >= FRAME_BITS) begin
            done = 1'b1;
            bits_sent = '0;
            if (gap_cfg == 16'd0) begin
              mode_q = MODE_IDLE;
              ticks_left = '0;
            end else begin
              mode_q = MODE_GAP;
              ticks_left = gap_cfg;
            end
          end else begin
            ticks_left = segment_reload(frame_q[13]);
          end
        end
      end
    end else if (mode_q == MODE_GAP) begin
      if (ticks_left != 16'd0) ticks_left = ticks_left - 16'd1;
      if (ticks_left == 16'd0) mode_q = MODE_IDLE;
    end
    res.line_level  = line_q;
    res.busy_res    = (mode_q == MODE_SEND || mode_q == MODE_GAP);
    res.accepted    = acc;
    res.packet_done = done;
  endtask

  // Offer one word in bursts with random gaps, then queue the result it should cause.
  task automatic send_word(input logic op, input logic [3:0] addr, input logic [3:0] nib,
                           input logic typed, input result_t typed_res, output bit counted);
    int unsigned pause;
    bit          was_idle;
    result_t     predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      pause = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
      if (pause != 0) begin
        s_tvalid <= 1'b0;
        repeat (pause) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {nib, addr};
    do begin
      @(posedge clk);
    end while (!s_tready);
    was_idle = (mode_q == MODE_IDLE);
    advance_encoder(op, addr, nib, predicted);
    line_words_q.push_back(typed ? typed_res : predicted);
    counted = predicted.accepted || (op == OP_TICK && !was_idle);
  endtask

  // Random traffic until the goal is met; ticks dominate while a frame is on the line.
  task automatic run_traffic(input run_goal_t goal, input int unsigned budget);
    int unsigned counted;
    bit          started;
    bit          finished;
    bit          eff;
    logic        op;
    logic [3:0]  addr_r;
    logic [3:0]  nib_r;
    counted = 0;
    started = 1'b0;
    finished = 1'b0;
    while (!finished) begin
      if (mode_q != MODE_IDLE) started = 1'b1;
      case (goal)
        RUN_TO_IDLE: finished = started && mode_q == MODE_IDLE;
        RUN_ONE_BIT: finished = mode_q == MODE_SEND && bits_sent >= 4'd1;
        default:     finished = counted >= budget;
      endcase
      if (!finished) begin
        if (mode_q == MODE_IDLE)
          op = (goal != RUN_FOR_COUNT || $urandom_range(0, 1) == 0) ? OP_LOAD : OP_TICK;
        else
          op = ($urandom_range(0, 49) == 0) ? OP_LOAD : OP_TICK;
        addr_r = 4'($urandom);
        nib_r = 4'($urandom);
        send_word(op, addr_r, nib_r, 1'b0, '0, eff);
        if (eff) counted++;
      end
    end
  endtask

  // Stop offering and wait for every outstanding result word.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (line_words_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Register write; valid stays high into the next write of a sequence.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    if (last) cfg_valid <= 1'b0;
    case (idx)
      CFG_HALF_BIT: half_cfg = value[7:0];
      CFG_GAP:      gap_cfg = value;
      default:      ;
    endcase
  endtask

  function automatic probe_t row_typed(input logic op, input logic [3:0] addr,
                                       input logic [3:0] nib, input logic line,
                                       input logic busy, input logic acc, input logic done);
    probe_t p;
    p.op = op;
    p.addr = addr;
    p.nib = nib;
    p.typed = 1'b1;
    p.result.line_level = line;
    p.result.busy_res = busy;
    p.result.accepted = acc;
    p.result.packet_done = done;
    return p;
  endfunction

  function automatic probe_t row_free(input logic op, input logic [3:0] addr,
                                      input logic [3:0] nib);
    probe_t p;
    p = '0;
    p.op = op;
    p.addr = addr;
    p.nib = nib;
    return p;
  endfunction

  function automatic void check_field(input string what, input logic exp, input logic act);
    if (act !== exp) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s expected %0b, got %0b", $time, what, exp, act);
    end
  endfunction

  // Main stimulus: directed rows at reset settings, then phases of random traffic.
  initial begin : stimulus
    probe_t     directed [0:19];
    bit         eff;
    logic [7:0] junk;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Idle tick, loads at the nibble extremes, loads while busy, first cell of a one.
    directed[0] = row_typed(OP_TICK, 4'h5, 4'hA, 1'b0, 1'b0, 1'b0, 1'b0);
    directed[1] = row_typed(OP_TICK, 4'hF, 4'hF, 1'b0, 1'b0, 1'b0, 1'b0);
    directed[2] = row_typed(OP_LOAD, 4'hF, 4'hF, 1'b1, 1'b1, 1'b1, 1'b0);
    directed[3] = row_typed(OP_LOAD, 4'h0, 4'h0, 1'b1, 1'b1, 1'b0, 1'b0);
    directed[4] = row_typed(OP_LOAD, 4'hA, 4'h5, 1'b1, 1'b1, 1'b0, 1'b0);
    for (int i = 5; i < 19; i++)
      directed[i] = row_free(OP_TICK, 4'(i), 4'(~i));
    directed[19] = row_typed(OP_LOAD, 4'h3, 4'hC, 1'b0, 1'b1, 1'b0, 1'b0);
    for (int i = 0; i < 20; i++)
      send_word(directed[i].op, directed[i].addr, directed[i].nib,
                directed[i].typed, directed[i].result, eff);
    drain();

    // Shorten the rest of the first frame and its gap while the frame is running.
    write_reg(CFG_HALF_BIT, 16'd1, 1'b0);
    write_reg(CFG_GAP, 16'd8, 1'b1);
    run_traffic(RUN_TO_IDLE, 0);
    drain();

    // A long cell whose reload needs the ninth bit; then switch cell and gap mid-frame.
    junk = 8'($urandom);
    write_reg(CFG_HALF_BIT, {junk, 8'd129}, 1'b1);
    run_traffic(RUN_ONE_BIT, 0);
    drain();
    junk = 8'($urandom);
    write_reg(CFG_HALF_BIT, {junk, 8'd1}, 1'b0);
    write_reg(CFG_GAP, 16'd3, 1'b1);
    run_traffic(RUN_TO_IDLE, 0);
    drain();

    // Zero half period and zero gap; an unused index must change nothing.
    write_reg(CFG_UNUSED, 16'($urandom), 1'b0);
    write_reg(CFG_HALF_BIT, 16'h0000, 1'b0);
    write_reg(CFG_GAP, 16'h0000, 1'b1);
    run_traffic(RUN_FOR_COUNT, 40);
    drain();

    // The receiver holds off for a long stretch during this phase.
    squeeze_req <= 1'b1;
    write_reg(CFG_HALF_BIT, 16'd2, 1'b0);
    write_reg(CFG_GAP, 16'd5, 1'b1);
    run_traffic(RUN_FOR_COUNT, 50);
    drain();

    write_reg(CFG_HALF_BIT, 16'd1, 1'b0);
    write_reg(CFG_GAP, 16'd1, 1'b1);
    run_traffic(RUN_FOR_COUNT, 40);
    drain();

    write_reg(CFG_HALF_BIT, 16'($urandom_range(2, 4)), 1'b0);
    write_reg(CFG_GAP, 16'($urandom_range(0, 20)), 1'b1);
    run_traffic(RUN_FOR_COUNT, 50);
    drain();

    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Result side: check each word taken, then pick the next ready level.
  initial begin : result_monitor
    result_t      exp;
    ready_style_t style;
    int unsigned  epoch;
    int unsigned  beat;
    int unsigned  hold;
    bit           squeeze_done;
    style = READY_ALWAYS;
    epoch = 0;
    beat = 0;
    hold = 0;
    squeeze_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (m_tvalid && m_tready) begin
          if (line_words_q.size() == 0) begin
            mismatches++;
            $display("%0t: result word with none expected, got data %0h last %0b",
                     $time, m_tdata, m_tlast);
          end else begin
            exp = line_words_q.pop_front();
            check_field("line_level", exp.line_level, m_tdata[0]);
            check_field("busy_res", exp.busy_res, m_tdata[1]);
            check_field("accepted", exp.accepted, m_tdata[2]);
            check_field("packet_done", exp.packet_done, m_tlast);
          end
        end

        if (squeeze_req && !squeeze_done) begin
          squeeze_done = 1'b1;
          hold = SQUEEZE_CYCLES;
        end
        if (epoch == 0) begin
          case ($urandom_range(0, 2))
            0:       style = READY_ALWAYS;
            1:       style = READY_RANDOM;
            default: style = READY_PERIODIC;
          endcase
          epoch = 128;
        end
        epoch--;
        beat = (beat == 4) ? 0 : beat + 1;

        if (hold != 0) begin
          hold--;
          m_tready <= 1'b0;
        end else begin
          case (style)
            READY_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
            READY_PERIODIC: m_tready <= (beat >= 2);
            default:        m_tready <= 1'b1;
          endcase
        end
      end
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule
